### sv/lrk4dw_pkg.sv
// shared types, constants and helpers for the rk4 langevin double-well step block
// no dependencies
`default_nettype none

package lrk4dw_pkg;

	localparam int HIST_BINS = 1024;
	localparam int HIST_AW   = $clog2(HIST_BINS);

	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [1:0] MODE_STEP    = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [2:0] REG_POTENTIAL = 3'd0;
	localparam logic [2:0] REG_INERTIA   = 3'd1;
	localparam logic [2:0] REG_FRICTION  = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_START     = 3'd4;
	localparam logic [2:0] REG_LEFT      = 3'd5;
	localparam logic [2:0] REG_INV_WIDTH = 3'd6;
	localparam logic [2:0] REG_INTERVAL  = 3'd7;

	localparam logic signed [52:0] ONE_Q = 53'sd4294967296;
	localparam logic signed [52:0] MAX53 = 53'sd140737488355327;
	localparam logic signed [52:0] MIN53 = -53'sd140737488355328;
	localparam logic [7:0] DIV6_RECIP = 8'd43;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [47:0] noise;
		logic               warmup;
		logic [9:0]         bin_index;
	} in_t;

	typedef struct packed {
		logic signed [47:0] position;
		logic signed [47:0] velocity;
		logic               sample_valid;
		logic [31:0]        step_number;
		logic [31:0]        bin_count;
		logic               out_of_range;
	} out_t;

	typedef struct packed {
		logic               start;
		logic signed [51:0] a;
		logic signed [51:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [47:0] res;
	} mul_rsp_t;

	function automatic logic signed [52:0] ext53(input logic signed [47:0] v);
		return {{5{v[47]}}, v};
	endfunction

	function automatic logic signed [51:0] ext52(input logic signed [47:0] v);
		return {{4{v[47]}}, v};
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
		if (v > MAX53) begin
			return 48'sh7FFF_FFFF_FFFF;
		end else if (v < MIN53) begin
			return 48'sh8000_0000_0000;
		end
		return v[47:0];
	endfunction

	function automatic logic signed [47:0] add_sat(input logic signed [47:0] a,
		input logic signed [47:0] b);
		return sat48(ext53(a) + ext53(b));
	endfunction

	function automatic logic signed [47:0] sub_sat(input logic signed [47:0] a,
		input logic signed [47:0] b);
		return sat48(ext53(a) - ext53(b));
	endfunction

	// one radix-16 digit of a divide by six: {quotient digit, remainder}
	function automatic logic [6:0] div6_digit(input logic [6:0] n);
		logic [14:0] p;
		logic [3:0]  qd;
		logic [6:0]  rm;
		p  = 15'(n) * 15'(DIV6_RECIP);
		qd = p[11:8];
		rm = n - 7'(qd) * 7'd6;
		return {qd, rm[2:0]};
	endfunction

endpackage

`default_nettype wire

### sv/lrk4dw_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module lrk4dw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/lrk4dw_mul.sv
// shared q16.32 multiplier: four 32x32 partial products in sequence,
// magnitude truncation and 48-bit saturation; depends on lrk4dw_pkg
`default_nettype none

module lrk4dw_mul (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lrk4dw_pkg::mul_req_t  req,
	output lrk4dw_pkg::mul_rsp_t  rsp
);

	logic [51:0]        ma_q, mb_q;
	logic               neg_q;
	logic [2:0]         ph_q;
	logic               run_q;
	logic [55:0]        acc_q;
	logic               big_q;
	logic               done_q;
	logic signed [47:0] res_q;

	logic [31:0] op_x, op_y;
	logic [63:0] prod;
	logic [51:0] amag, bmag;
	logic [47:0] rmag;

	assign amag = req.a[51] ? 52'(-req.a) : 52'(req.a);
	assign bmag = req.b[51] ? 52'(-req.b) : 52'(req.b);

	always_comb begin
		case (ph_q)
			3'd0:    begin op_x = ma_q[31:0];          op_y = mb_q[31:0];          end
			3'd1:    begin op_x = {12'b0, ma_q[51:32]}; op_y = mb_q[31:0];          end
			3'd2:    begin op_x = ma_q[31:0];          op_y = {12'b0, mb_q[51:32]}; end
			default: begin op_x = {12'b0, ma_q[51:32]}; op_y = {12'b0, mb_q[51:32]}; end
		endcase
	end

	assign prod = op_x * op_y;

	always_comb begin
		if (big_q || acc_q > 56'h80_0000_0000_00) begin
			rmag = 48'h8000_0000_0000;
		end else begin
			rmag = acc_q[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q   <= '0;
			mb_q   <= '0;
			neg_q  <= 1'b0;
			ph_q   <= '0;
			run_q  <= 1'b0;
			acc_q  <= '0;
			big_q  <= 1'b0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= !req.start && run_q && (ph_q == 3'd4);
			if (req.start) begin
				ma_q  <= amag;
				mb_q  <= bmag;
				neg_q <= req.a[51] ^ req.b[51];
				ph_q  <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				ph_q <= ph_q + 3'd1;
				case (ph_q)
					3'd0: acc_q <= {24'b0, prod[63:32]};
					3'd1, 3'd2: acc_q <= acc_q + prod[55:0];
					3'd3: begin
						big_q <= (prod[63:15] != '0);
						acc_q <= acc_q + {prod[23:0], 32'b0};
					end
					default: begin
						run_q <= 1'b0;
						if (neg_q) begin
							res_q <= -$signed(rmag);
						end else if (rmag == 48'h8000_0000_0000) begin
							res_q <= 48'sh7FFF_FFFF_FFFF;
						end else begin
							res_q <= $signed(rmag);
						end
					end
				endcase
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

### sv/langevin_rk4_double_well_step.sv
// top level of the rk4 langevin double-well step block: sequencer, state,
// apb registers and histogram; depends on lrk4dw_pkg, lrk4dw_mul, lrk4dw_ram
//
// usage:
// step channel (valid/ready) takes one beat per item: mode 0 integrates one
// rk4 step with the given noise sample, mode 1 reads a histogram bin,
// mode 2 restarts the trajectory, mode 3 only reports the state.
// result channel (valid/ready) returns exactly one beat per item.
// a step beat runs 32 products through the one shared multiplier, a
// divide by six one radix-16 digit at a time, then binning and a
// read-modify-write of the histogram ram. read beats wait on a ram read;
// restart and mode 3 beats go straight to the output register.
// step_ready is high only while no item is in progress; a finished result
// waits in the output register, so a new item is taken while the receiver
// stalls, and its result waits until the register is free.
// after reset the histogram ram is cleared one bin a cycle, all 1024 bins,
// with step_ready low; apb writes are taken as ever. registers return to
// their reset values and position, velocity and counters clear.
`default_nettype none

module langevin_rk4_double_well_step (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step_valid,
	output logic                       step_ready,
	input  lrk4dw_pkg::in_t            step,
	output logic                       result_valid,
	input  wire                        result_ready,
	output lrk4dw_pkg::out_t           result,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [lrk4dw_pkg::PADDR_W-1:0] paddr,
	input  wire [lrk4dw_pkg::PDATA_W-1:0] pwdata,
	output logic [lrk4dw_pkg::PDATA_W-1:0] prdata,
	output logic                       pready
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ISSUE, S_WAIT, S_DLOAD, S_DIV, S_UPD,
		S_BIN0, S_BIN1, S_BIN2, S_HRD, S_HWR, S_QRD, S_QWAIT, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_SQ, OP_T, OP_F, OP_FV, OP_FG, OP_DP, OP_DV, OP_DG
	} op_t;

	// configuration registers
	logic [31:0]        pot_q, inertia_q, friction_q, dt_q, inv_width_q;
	logic signed [47:0] start_q, left_q;
	logic [15:0]        interval_q;

	state_t state_q;
	op_t    op_q;
	logic [1:0] stage_q;
	logic [lrk4dw_pkg::HIST_AW-1:0] clr_q, bin_q;

	logic [1:0]         mode_q;
	logic signed [47:0] noise_q;
	logic               warm_q;
	logic [9:0]         bidx_q;

	logic signed [47:0] xs_q [3];
	logic signed [47:0] xt_q [3];
	logic signed [47:0] kk_q [3];
	logic signed [50:0] sum_q [3];
	logic signed [47:0] dq_q [3];
	logic [47:0]        dw_q [3];
	logic [2:0]         drem_q [3];
	logic               dn_q [3];
	logic [3:0]         dcnt_q;
	logic signed [47:0] t_q, u_q, hold_q;

	logic [31:0] stepc_q;
	logic [15:0] intv_q;
	logic        valid_q, oor_q;
	logic [31:0] stepno_q, count_q;
	logic [47:0] d_q;
	logic [63:0] prod_q;

	logic              result_valid_q;
	lrk4dw_pkg::out_t  result_q;

	lrk4dw_pkg::mul_req_t mreq;
	lrk4dw_pkg::mul_rsp_t mrsp;

	logic signed [51:0] k_op, m_op, g_op, dt_op;
	logic [1:0]         lane;
	logic signed [47:0] r, r_scaled, x_lane, xt_new, kg_new;
	logic               w2;
	logic [6:0]         dnext [3];
	logic signed [48:0] diff;
	logic [31:0]        bsel;
	logic [63:0]        bprod;
	logic [48:0]        hi;
	logic [32:0]        bin_full;
	logic [16:0]        intv_nxt;
	logic [15:0]        iv;
	logic [31:0]        bidx_ext;
	logic               ram_we;
	logic [lrk4dw_pkg::HIST_AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;
	logic               wr_en;

	lrk4dw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	lrk4dw_ram #(
		.WIDTH (32),
		.DEPTH (lrk4dw_pkg::HIST_BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// apb registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_q       <= 32'd16777216;
			inertia_q   <= 32'd16777216;
			friction_q  <= 32'd16777216;
			dt_q        <= 32'd42949673;
			start_q     <= 48'shFFFF_0000_0000;
			left_q      <= 48'shFFFE_0000_0000;
			inv_width_q <= 32'd16777216;
			interval_q  <= 16'd1;
		end else if (wr_en) begin
			unique case (paddr[5:3])
				lrk4dw_pkg::REG_POTENTIAL: pot_q       <= pwdata[31:0];
				lrk4dw_pkg::REG_INERTIA:   inertia_q   <= pwdata[31:0];
				lrk4dw_pkg::REG_FRICTION:  friction_q  <= pwdata[31:0];
				lrk4dw_pkg::REG_STEP:      dt_q        <= pwdata[31:0];
				lrk4dw_pkg::REG_START:     start_q     <= $signed(pwdata[47:0]);
				lrk4dw_pkg::REG_LEFT:      left_q      <= $signed(pwdata[47:0]);
				lrk4dw_pkg::REG_INV_WIDTH: inv_width_q <= pwdata[31:0];
				lrk4dw_pkg::REG_INTERVAL:  interval_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			lrk4dw_pkg::REG_POTENTIAL: prdata = {32'b0, pot_q};
			lrk4dw_pkg::REG_INERTIA:   prdata = {32'b0, inertia_q};
			lrk4dw_pkg::REG_FRICTION:  prdata = {32'b0, friction_q};
			lrk4dw_pkg::REG_STEP:      prdata = {32'b0, dt_q};
			lrk4dw_pkg::REG_START:     prdata = {{16{start_q[47]}}, start_q};
			lrk4dw_pkg::REG_LEFT:      prdata = {{16{left_q[47]}}, left_q};
			lrk4dw_pkg::REG_INV_WIDTH: prdata = {32'b0, inv_width_q};
			lrk4dw_pkg::REG_INTERVAL:  prdata = {48'b0, interval_q};
			default:                   prdata = '0;
		endcase
	end

	// multiplier operands
	assign k_op  = -$signed({10'b0, pot_q, 10'b0});
	assign m_op  = $signed({12'b0, inertia_q, 8'b0});
	assign g_op  = $signed({12'b0, friction_q, 8'b0});
	assign dt_op = $signed({20'b0, dt_q});

	always_comb begin
		mreq.start = (state_q == S_ISSUE);
		lane       = 2'd0;
		case (op_q)
			OP_SQ: begin mreq.a = lrk4dw_pkg::ext52(xt_q[0]); mreq.b = lrk4dw_pkg::ext52(xt_q[0]); end
			OP_T:  begin mreq.a = k_op; mreq.b = lrk4dw_pkg::ext52(t_q); end
			OP_F:  begin mreq.a = lrk4dw_pkg::ext52(u_q); mreq.b = lrk4dw_pkg::ext52(xt_q[0]); end
			OP_FV: begin mreq.a = m_op; mreq.b = lrk4dw_pkg::ext52(hold_q); end
			OP_FG: begin mreq.a = g_op; mreq.b = lrk4dw_pkg::ext52(hold_q); end
			OP_DP: begin
				lane   = 2'd0;
				mreq.a = dt_op;
				mreq.b = (stage_q == 2'd3) ? {sum_q[0][50], sum_q[0]}
					: lrk4dw_pkg::ext52(kk_q[0]);
			end
			OP_DV: begin
				lane   = 2'd1;
				mreq.a = dt_op;
				mreq.b = (stage_q == 2'd3) ? {sum_q[1][50], sum_q[1]}
					: lrk4dw_pkg::ext52(kk_q[1]);
			end
			default: begin
				lane   = 2'd2;
				mreq.a = dt_op;
				mreq.b = (stage_q == 2'd3) ? {sum_q[2][50], sum_q[2]}
					: lrk4dw_pkg::ext52(kk_q[2]);
			end
		endcase
	end

	assign r = mrsp.res;

	always_comb begin
		case (lane)
			2'd0:    x_lane = xs_q[0];
			2'd1:    x_lane = xs_q[1];
			default: x_lane = xs_q[2];
		endcase
	end

	// halving truncates toward zero
	assign r_scaled = (stage_q == 2'd2) ? r : ((r + $signed({47'b0, r[47]})) >>> 1);
	assign xt_new   = lrk4dw_pkg::add_sat(x_lane, r_scaled);
	assign kg_new   = lrk4dw_pkg::sat48(-lrk4dw_pkg::ext53(r));
	assign w2       = (stage_q == 2'd1) || (stage_q == 2'd2);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dnext[i] = lrk4dw_pkg::div6_digit({drem_q[i], dw_q[i][47:44]});
		end
	end

	// binning
	assign diff     = {xs_q[0][47], xs_q[0]} - {left_q[47], left_q};
	assign bsel     = (state_q == S_BIN1) ? d_q[31:0] : {16'b0, d_q[47:32]};
	assign bprod    = bsel * inv_width_q;
	assign hi       = {17'b0, prod_q[63:32]} + bprod[48:0];
	assign bin_full = hi[48:16];

	assign iv       = (interval_q == '0) ? 16'd1 : interval_q;
	assign intv_nxt = {1'b0, intv_q} + 17'd1;
	assign bidx_ext = 32'(bidx_q);

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_HWR);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : bin_q;
	assign ram_wdata = (state_q == S_CLEAR) ? 32'd0
		: ((ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1);
	assign ram_raddr = (mode_q == lrk4dw_pkg::MODE_READ)
		? bidx_ext[lrk4dw_pkg::HIST_AW-1:0] : bin_q;

	assign step_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			op_q           <= OP_SQ;
			stage_q        <= '0;
			clr_q          <= '0;
			bin_q          <= '0;
			mode_q         <= '0;
			noise_q        <= '0;
			warm_q         <= 1'b0;
			bidx_q         <= '0;
			for (int i = 0; i < 3; i++) begin
				xs_q[i]   <= '0;
				xt_q[i]   <= '0;
				kk_q[i]   <= '0;
				sum_q[i]  <= '0;
				dq_q[i]   <= '0;
				dw_q[i]   <= '0;
				drem_q[i] <= '0;
				dn_q[i]   <= 1'b0;
			end
			dcnt_q         <= '0;
			t_q            <= '0;
			u_q            <= '0;
			hold_q         <= '0;
			stepc_q        <= '0;
			intv_q         <= '0;
			valid_q        <= 1'b0;
			oor_q          <= 1'b0;
			stepno_q       <= '0;
			count_q        <= '0;
			d_q            <= '0;
			prod_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && state_q != S_OUT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + lrk4dw_pkg::HIST_AW'(1);
					if (clr_q == lrk4dw_pkg::HIST_AW'(lrk4dw_pkg::HIST_BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (step_valid) begin
						mode_q   <= step.mode;
						noise_q  <= step.noise;
						warm_q   <= step.warmup;
						bidx_q   <= step.bin_index;
						valid_q  <= 1'b0;
						oor_q    <= 1'b0;
						stepno_q <= '0;
						count_q  <= '0;
						unique case (step.mode)
							lrk4dw_pkg::MODE_STEP: begin
								for (int i = 0; i < 3; i++) begin
									xt_q[i]  <= xs_q[i];
									sum_q[i] <= '0;
								end
								stage_q <= '0;
								op_q    <= OP_SQ;
								state_q <= S_ISSUE;
							end
							lrk4dw_pkg::MODE_READ: state_q <= S_QRD;
							lrk4dw_pkg::MODE_RESTART: begin
								xs_q[0] <= start_q;
								xs_q[1] <= '0;
								xs_q[2] <= '0;
								stepc_q <= '0;
								intv_q  <= '0;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (mrsp.done) begin
						state_q <= S_ISSUE;
						op_q    <= op_t'(op_q + 3'd1);
						case (op_q)
							OP_SQ: t_q <= lrk4dw_pkg::sat48(lrk4dw_pkg::ext53(r) - lrk4dw_pkg::ONE_Q);
							OP_T:  u_q <= r;
							OP_F:  hold_q <= lrk4dw_pkg::add_sat(xt_q[2], r);
							OP_FV: begin
								kk_q[1] <= r;
								hold_q  <= lrk4dw_pkg::sub_sat(
									lrk4dw_pkg::add_sat(xt_q[2], xt_q[1]), noise_q);
							end
							OP_FG: begin
								kk_q[0] <= xt_q[1];
								kk_q[2] <= kg_new;
								sum_q[0] <= sum_q[0] + (w2 ? {{2{xt_q[1][47]}}, xt_q[1], 1'b0}
									: {{3{xt_q[1][47]}}, xt_q[1]});
								sum_q[1] <= sum_q[1] + (w2 ? {{2{kk_q[1][47]}}, kk_q[1], 1'b0}
									: {{3{kk_q[1][47]}}, kk_q[1]});
								sum_q[2] <= sum_q[2] + (w2 ? {{2{kg_new[47]}}, kg_new, 1'b0}
									: {{3{kg_new[47]}}, kg_new});
							end
							default: begin
								for (int i = 0; i < 3; i++) begin
									if (lane == 2'(i)) begin
										if (stage_q == 2'd3) begin
											dq_q[i] <= r;
										end else begin
											xt_q[i] <= xt_new;
										end
									end
								end
								if (op_q == OP_DG) begin
									op_q <= OP_SQ;
									if (stage_q == 2'd3) begin
										state_q <= S_DLOAD;
									end else begin
										stage_q <= stage_q + 2'd1;
									end
								end
							end
						endcase
					end
				end
				S_DLOAD: begin
					for (int i = 0; i < 3; i++) begin
						dw_q[i]   <= dq_q[i][47] ? 48'(-dq_q[i]) : 48'(dq_q[i]);
						dn_q[i]   <= dq_q[i][47];
						drem_q[i] <= '0;
					end
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					for (int i = 0; i < 3; i++) begin
						dw_q[i]   <= {dw_q[i][43:0], dnext[i][6:3]};
						drem_q[i] <= dnext[i][2:0];
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd11) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					for (int i = 0; i < 3; i++) begin
						xs_q[i] <= lrk4dw_pkg::add_sat(xs_q[i],
							dn_q[i] ? -$signed(dw_q[i]) : $signed(dw_q[i]));
					end
					state_q <= S_BIN0;
				end
				S_BIN0: begin
					if (!warm_q) begin
						if (intv_q == '0) begin
							valid_q  <= 1'b1;
							stepno_q <= stepc_q;
						end
						stepc_q <= stepc_q + 32'd1;
						intv_q  <= (intv_nxt >= {1'b0, iv}) ? 16'd0 : intv_nxt[15:0];
					end
					if (diff[48]) begin
						oor_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						d_q     <= diff[47:0];
						state_q <= S_BIN1;
					end
				end
				S_BIN1: begin
					prod_q  <= bprod;
					state_q <= S_BIN2;
				end
				S_BIN2: begin
					if (bin_full >= 33'(lrk4dw_pkg::HIST_BINS)) begin
						oor_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						bin_q   <= bin_full[lrk4dw_pkg::HIST_AW-1:0];
						state_q <= S_HRD;
					end
				end
				S_HRD: state_q <= S_HWR;
				S_HWR: state_q <= S_OUT;
				S_QRD: begin
					if (bidx_ext >= 32'(lrk4dw_pkg::HIST_BINS)) begin
						oor_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_QWAIT;
					end
				end
				S_QWAIT: begin
					count_q <= ram_rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q        <= 1'b1;
						result_q.position     <= xs_q[0];
						result_q.velocity     <= xs_q[1];
						result_q.sample_valid <= valid_q;
						result_q.step_number  <= stepno_q;
						result_q.bin_count    <= count_q;
						result_q.out_of_range <= oor_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !step_ready)
		else $error("second beat taken while an item is in progress");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> state_q == S_WAIT)
		else $error("product finished outside the wait state");

	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_HWR))
		else $error("histogram written outside clear or update");

endmodule

`default_nettype wire

### sim/tb_langevin_rk4_double_well_step.sv
// self-checking testbench for langevin_rk4_double_well_step: an in-bench rk4 and histogram
// predictor checks every result beat, apb register sweeps, random idling and backpressure
// depends on lrk4dw_pkg and the langevin_rk4_double_well_step rtl
`default_nettype none

module tb_langevin_rk4_double_well_step;

	localparam logic [1:0] MODE_REPORT = 2'd3;
	localparam longint MAXQ = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint MINQ = -MAXQ - 1;
	localparam longint ONE_FIX = 64'sh1_0000_0000;
	localparam bit [63:0] LO32 = 64'h0000_0000_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic step_valid = 1'b0;
	logic step_ready;
	lrk4dw_pkg::in_t step = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	lrk4dw_pkg::out_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [lrk4dw_pkg::PADDR_W-1:0] paddr = '0;
	logic [lrk4dw_pkg::PDATA_W-1:0] pwdata = '0;
	logic [lrk4dw_pkg::PDATA_W-1:0] prdata;
	logic pready;

	langevin_rk4_double_well_step dut (
		.clk(clk), .arst_n(arst_n),
		.step_valid(step_valid), .step_ready(step_ready), .step(step),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// predictor copy of registers and state
	bit [31:0] gain_v0 = 32'd16777216, gain_m = 32'd16777216, gain_g = 32'd16777216;
	bit [31:0] dt_q = 32'd42949673, inv_width_q = 32'd16777216;
	longint start_q = -64'sd4294967296, left_q = -64'sd8589934592;
	bit [15:0] interval_q = 16'd1;
	longint traj[0:2];
	longint xs[0:2];
	longint kv[0:3][0:2];
	bit [31:0] emitted_steps, phase_cnt;
	bit [31:0] bin_hits[0:lrk4dw_pkg::HIST_BINS-1];

	lrk4dw_pkg::out_t expected_results[$];
	int mismatches = 0;
	int n_steps = 0, n_reads = 0, n_restarts = 0, n_samples = 0, n_outside = 0;
	int hold_left = 0;
	bit quiet = 1'b0;

	function automatic longint clamp48(longint v);
		if (v > MAXQ) return MAXQ;
		if (v < MINQ) return MINQ;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		bit neg;
		bit [63:0] ma, mb, hh, r;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		hh = (ma >> 32) * (mb >> 32);
		if (hh >= 64'd32768) begin
			r = 64'd1 << 47;
		end else begin
			r = (hh << 32) + (ma >> 32) * (mb & LO32) + (ma & LO32) * (mb >> 32)
				+ (((ma & LO32) * (mb & LO32)) >> 32);
		end
		if (r > (64'd1 << 47)) r = 64'd1 << 47;
		return neg ? clamp48(-longint'(r)) : clamp48(longint'(r));
	endfunction

	task automatic eval_rates(int j, longint nz);
		longint v0, m, g, t, kk, fx;
		v0 = longint'(gain_v0) << 8;
		m = longint'(gain_m) << 8;
		g = longint'(gain_g) << 8;
		t = clamp48(qmul(xs[0], xs[0]) - ONE_FIX);
		kk = clamp48(-4 * v0);
		fx = qmul(qmul(kk, t), xs[0]);
		kv[j][0] = xs[1];
		kv[j][1] = qmul(m, clamp48(xs[2] + fx));
		kv[j][2] = clamp48(-qmul(g, clamp48(clamp48(xs[2] + xs[1]) - nz)));
	endtask

	task automatic rk4_advance(longint nz);
		longint dt;
		dt = longint'(dt_q);
		for (int i = 0; i < 3; i++) xs[i] = traj[i];
		eval_rates(0, nz);
		for (int i = 0; i < 3; i++) xs[i] = clamp48(traj[i] + qmul(dt, kv[0][i]) / 2);
		eval_rates(1, nz);
		for (int i = 0; i < 3; i++) xs[i] = clamp48(traj[i] + qmul(dt, kv[1][i]) / 2);
		eval_rates(2, nz);
		for (int i = 0; i < 3; i++) xs[i] = clamp48(traj[i] + qmul(dt, kv[2][i]));
		eval_rates(3, nz);
		for (int i = 0; i < 3; i++)
			traj[i] = clamp48(traj[i] + qmul(dt, kv[0][i] + 2 * kv[1][i] + 2 * kv[2][i]
				+ kv[3][i]) / 6);
	endtask

	// returns 1 when the position misses the histogram
	function automatic bit bin_position();
		longint diff;
		bit [63:0] d, hi, bin;
		diff = traj[0] - left_q;
		if (diff < 0) return 1'b1;
		d = 64'(diff);
		hi = (d >> 32) * 64'(inv_width_q) + (((d & LO32) * 64'(inv_width_q)) >> 32);
		bin = hi >> 16;
		if (bin >= 64'(lrk4dw_pkg::HIST_BINS)) return 1'b1;
		if (bin_hits[bin] != 32'hFFFF_FFFF) bin_hits[bin]++;
		return 1'b0;
	endfunction

	task automatic predict_result(input lrk4dw_pkg::in_t it, output lrk4dw_pkg::out_t exp);
		bit [31:0] iv;
		exp = '0;
		case (it.mode)
			lrk4dw_pkg::MODE_STEP: begin
				rk4_advance(longint'($signed(it.noise)));
				exp.out_of_range = bin_position();
				if (!it.warmup) begin
					iv = (interval_q == 0) ? 32'd1 : 32'(interval_q);
					if (phase_cnt == 0) begin
						exp.sample_valid = 1'b1;
						exp.step_number = emitted_steps;
					end
					emitted_steps++;
					phase_cnt++;
					if (phase_cnt >= iv) phase_cnt = 0;
				end
				n_steps++;
			end
			lrk4dw_pkg::MODE_READ: begin
				exp.bin_count = bin_hits[it.bin_index];
				n_reads++;
			end
			lrk4dw_pkg::MODE_RESTART: begin
				traj[0] = start_q;
				traj[1] = 0;
				traj[2] = 0;
				emitted_steps = 0;
				phase_cnt = 0;
				n_restarts++;
			end
			default: ;
		endcase
		exp.position = traj[0][47:0];
		exp.velocity = traj[1][47:0];
	endtask

	task automatic send_item(input lrk4dw_pkg::in_t it);
		lrk4dw_pkg::out_t exp;
		while (!quiet && $urandom_range(0, 99) < 21) begin
			@(negedge clk);
			step_valid <= 1'b0;
		end
		@(negedge clk);
		step_valid <= 1'b1;
		step <= it;
		do @(posedge clk); while (!step_ready);
		predict_result(it, exp);
		expected_results.push_back(exp);
	endtask

	task automatic send_one(logic [1:0] md, logic [47:0] nz, logic wu, logic [9:0] bi);
		lrk4dw_pkg::in_t it;
		it.mode = md;
		it.noise = nz;
		it.warmup = wu;
		it.bin_index = bi;
		send_item(it);
	endtask

	task automatic settle();
		@(negedge clk);
		step_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			lrk4dw_pkg::REG_POTENTIAL: gain_v0 = val[31:0];
			lrk4dw_pkg::REG_INERTIA:   gain_m = val[31:0];
			lrk4dw_pkg::REG_FRICTION:  gain_g = val[31:0];
			lrk4dw_pkg::REG_STEP:      dt_q = val[31:0];
			lrk4dw_pkg::REG_START:     start_q = longint'($signed(val[47:0]));
			lrk4dw_pkg::REG_LEFT:      left_q = longint'($signed(val[47:0]));
			lrk4dw_pkg::REG_INV_WIDTH: inv_width_q = val[31:0];
			lrk4dw_pkg::REG_INTERVAL:  interval_q = val[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(bit [31:0] v0, bit [31:0] m, bit [31:0] g, bit [31:0] dt,
		logic [47:0] sp, logic [47:0] lf, bit [31:0] iw, bit [15:0] oi);
		settle();
		reg_write(lrk4dw_pkg::REG_POTENTIAL, 64'(v0));
		reg_write(lrk4dw_pkg::REG_INERTIA, 64'(m));
		reg_write(lrk4dw_pkg::REG_FRICTION, 64'(g));
		reg_write(lrk4dw_pkg::REG_STEP, 64'(dt));
		reg_write(lrk4dw_pkg::REG_START, 64'(sp));
		reg_write(lrk4dw_pkg::REG_LEFT, 64'(lf));
		reg_write(lrk4dw_pkg::REG_INV_WIDTH, 64'(iw));
		reg_write(lrk4dw_pkg::REG_INTERVAL, 64'(oi));
	endtask

	function automatic logic [47:0] rand_noise();
		longint n;
		if ($urandom_range(0, 99) < 12) return 48'({$urandom, $urandom});
		n = longint'($urandom) << $urandom_range(0, 3);
		if ($urandom_range(0, 1)) n = -n;
		return n[47:0];
	endfunction

	// mostly step runs with occasional reads, restarts and unused-mode beats
	task automatic random_items(int count);
		int r;
		lrk4dw_pkg::in_t it;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			it.mode = (r < 70) ? lrk4dw_pkg::MODE_STEP : (r < 86) ? lrk4dw_pkg::MODE_READ :
				(r < 96) ? lrk4dw_pkg::MODE_RESTART : MODE_REPORT;
			it.noise = rand_noise();
			it.warmup = ($urandom_range(0, 99) < 20);
			it.bin_index = 10'($urandom);
			send_item(it);
		end
	endtask

	task automatic test_directed();
		send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, '0, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h0000_8000_0000, 1'b1, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'hFFFF_8000_0000, 1'b1, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h0000_4000_0000, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h0000_4000_0000, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_READ, 48'hFFFF_FFFF_FFFF, 1'b1, 10'd256);
		send_one(lrk4dw_pkg::MODE_READ, '0, 1'b0, 10'd0);
		send_one(lrk4dw_pkg::MODE_READ, '0, 1'b0, 10'd1023);
		send_one(MODE_REPORT, 48'hFFFF_FFFF_FFFF, 1'b1, 10'h3FF);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h7FFF_FFFF_FFFF, 1'b0, 10'h3FF);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h7FFF_FFFF_FFFF, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h8000_0000_0000, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h8000_0000_0000, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_STEP, 48'h8000_0000_0000, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_READ, '0, 1'b0, 10'd255);
		send_one(lrk4dw_pkg::MODE_RESTART, 48'h5555_5555_5555, 1'b1, 10'h2AA);
		send_one(lrk4dw_pkg::MODE_STEP, 48'hAAAA_AAAA_AAAA, 1'b0, 10'h155);
		send_one(MODE_REPORT, '0, 1'b0, '0);
		send_one(lrk4dw_pkg::MODE_READ, '0, 1'b0, 10'd256);
	endtask

	task automatic test_default_setting();
		random_items(300);
		quiet = 1'b1;
		random_items(80);
		quiet = 1'b0;
	endtask

	task automatic test_zero_setting();
		apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
		send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
		random_items(150);
	endtask

	task automatic test_max_setting();
		apply_setting('1, '1, '1, '1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, '1, 16'hFFFF);
		send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
		random_items(150);
		apply_setting('1, '1, '1, '1, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '1, 16'hFFFF);
		send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
		random_items(30);
	endtask

	task automatic test_typical_setting();
		apply_setting(32'h0100_0000, 32'h0200_0000, 32'h0080_0000, 32'h051E_B852,
			48'hFFFE_8000_0000, 48'hFFFD_0000_0000, 32'h0096_0000, 16'd3);
		send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
		random_items(300);
	endtask

	task automatic test_random_settings();
		for (int k = 0; k < 3; k++) begin
			apply_setting($urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
				$urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0CCC_CCCC),
				48'(-longint'($urandom_range(0, 3)) << 31),
				48'(-longint'($urandom_range(1, 4)) << 32),
				$urandom_range(32'h0001_0000, 32'h0300_0000), 16'($urandom_range(1, 8)));
			send_one(lrk4dw_pkg::MODE_RESTART, '0, 1'b0, '0);
			random_items(110);
		end
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 1500;
		random_items(14);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			result_ready <= quiet || ($urandom_range(0, 99) >= 21);
		end
	end

	always @(posedge clk) begin
		lrk4dw_pkg::out_t exp;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", result);
			end else begin
				exp = expected_results.pop_front();
				if (result.sample_valid) n_samples++;
				if (result.out_of_range) n_outside++;
				if (result.position !== exp.position || result.velocity !== exp.velocity
					|| result.sample_valid !== exp.sample_valid
					|| result.step_number !== exp.step_number
					|| result.bin_count !== exp.bin_count
					|| result.out_of_range !== exp.out_of_range) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected pos %h vel %h smp %b num %0d cnt %0d oor %b",
							exp.position, exp.velocity, exp.sample_valid, exp.step_number,
							exp.bin_count, exp.out_of_range);
						$display("          actual   pos %h vel %h smp %b num %0d cnt %0d oor %b",
							result.position, result.velocity, result.sample_valid,
							result.step_number, result.bin_count, result.out_of_range);
					end
				end
			end
		end
	end

	initial begin
		traj[0] = 0;
		traj[1] = 0;
		traj[2] = 0;
		emitted_steps = 0;
		phase_cnt = 0;
		for (int i = 0; i < lrk4dw_pkg::HIST_BINS; i++) bin_hits[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_default_setting();
		test_zero_setting();
		test_max_setting();
		test_typical_setting();
		test_backpressure();
		test_random_settings();
		settle();
		repeat (300) @(posedge clk);
		$display("covered %0d steps, %0d bin reads, %0d restarts over eight register settings",
			n_steps, n_reads, n_restarts);
		$display("saw %0d emitted samples and %0d out-of-range steps", n_samples, n_outside);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[langevin_rk4_double_well_step] OK");
		end else begin
			$display("[langevin_rk4_double_well_step] ERROR");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("[langevin_rk4_double_well_step] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
